// ----- rtl/cds_pkg.sv -----
// cds_pkg: shared constants and types for the dispatch scheduler
// no dependencies
package cds_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS = 16;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_ARRIVE = 2'd0;
    localparam logic [1:0] CMD_DEPART = 2'd1;
    localparam logic [1:0] CMD_PREEMPT = 2'd2;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SRTF = 2'd1;
    localparam logic [1:0] MODE_RR = 2'd2;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_SLICE = 1'b1;

    localparam logic KIND_DEPART = 1'b0;
    localparam logic KIND_PREEMPT = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [TIME_BITS-1:0] left;
    } entry_t;

    // queue operation broadcast to every cell
    typedef struct packed {
        logic pop;      // shift toward the front
        logic ins;      // sorted or positional insert
        logic front;    // insert at front
        logic tail;     // append at tail
        entry_t data;
    } qop_t;
endpackage

// ----- rtl/cds_cell.sv -----
// cds_cell: one ready-queue slot of the shift-register queue
// depends on cds_pkg
module cds_cell (
    input  logic clk,
    input  cds_pkg::qop_t op,
    input  logic valid_here,
    input  logic tail_here,
    input  logic prev_ins,
    input  cds_pkg::entry_t prev_entry,
    input  cds_pkg::entry_t next_entry,
    input  logic next_valid,
    output logic ins_here,
    output cds_pkg::entry_t entry
);
    import cds_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   goes_after;

    // in a sorted insert the new entry lands after every entry whose remainder is equal or smaller,
    // and once a cell takes the new entry every cell behind it shifts
    assign goes_after = valid_here && (entry_reg.left <= op.data.left);
    assign ins_here = op.front ? 1'b1 :
                      (op.tail ? tail_here : (prev_ins || !goes_after));

    always_comb
    begin
        entry_next = entry_reg;
        if (op.pop)
        begin
            if (next_valid)
                entry_next = next_entry;
        end
        else if (op.ins)
        begin
            if (prev_ins)
                entry_next = prev_entry;
            else if (ins_here)
                entry_next = op.data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule

// ----- rtl/cds_queue.sv -----
// cds_queue: row of queue cells with the fill count
// depends on cds_pkg, cds_cell
module cds_queue (
    input  logic clk,
    input  logic rst_n,
    input  cds_pkg::qop_t op,
    output cds_pkg::entry_t head,
    output logic [cds_pkg::CNT_BITS-1:0] count
);
    import cds_pkg::*;

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    entry_t cell_entry [QUEUE_DEPTH];
    logic   cell_ins [QUEUE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic   v_here;
            logic   t_here;
            logic   p_ins;
            entry_t p_ent;
            entry_t n_ent;
            logic   n_val;
            assign v_here = CNT_BITS'(g) < count_reg;
            assign t_here = CNT_BITS'(g) == count_reg;
            if (g == 0)
            begin : g_first
                assign p_ins = 1'b0;
                assign p_ent = cell_entry[0];
            end
            else
            begin : g_rest
                assign p_ins = cell_ins[g-1];
                assign p_ent = cell_entry[g-1];
            end
            if (g == QUEUE_DEPTH - 1)
            begin : g_last
                assign n_ent = cell_entry[g];
                assign n_val = 1'b0;
            end
            else
            begin : g_mid
                assign n_ent = cell_entry[g+1];
                assign n_val = 1'b1;
            end
            cds_cell u_cell (
                .clk       (clk),
                .op        (op),
                .valid_here(v_here),
                .tail_here (t_here),
                .prev_ins  (p_ins),
                .prev_entry(p_ent),
                .next_entry(n_ent),
                .next_valid(n_val),
                .ins_here  (cell_ins[g]),
                .entry     (cell_entry[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (op.pop)
            count_next = count_reg - 1'b1;
        else if (op.ins)
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign head = cell_entry[0];
    assign count = count_reg;
endmodule

// ----- rtl/cpu_dispatch_scheduler_unit.sv -----
// cpu_dispatch_scheduler_unit: running slot plus shift-register queue;
// SRTF inserts an arrival by remaining time (at the front if shorter than
// the running job), other modes append it at the tail; start leads to
// execute, then re-insert when a preemption pops the front and parks the
// running job, then done; busy is high meanwhile and holds off new items;
// results cannot be stalled; reset clears count, running slot and flags
module cpu_dispatch_scheduler_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [1:0] cmd,
    input  logic [cds_pkg::TIME_BITS-1:0] elapsed,
    input  logic [15:0] job_id,
    input  logic [cds_pkg::TIME_BITS-1:0] burst,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [cds_pkg::TIME_BITS-1:0] cfg_data,
    output logic done,
    output logic run_valid,
    output logic [15:0] run_id,
    output logic [cds_pkg::TIME_BITS-1:0] run_left,
    output logic req_valid,
    output logic req_kind,
    output logic [cds_pkg::TIME_BITS-1:0] req_delay,
    output logic [4:0] queue_count,
    output logic overflow
);
    import cds_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_REIN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] st_reg, st_next;
    logic [1:0] mode_reg;
    logic [TIME_BITS-1:0] slice_reg;

    // latched item
    logic [1:0] cmd_reg;
    logic [15:0] id_reg;
    logic [TIME_BITS-1:0] burst_reg;

    // running slot
    logic run_reg, run_next;
    logic [15:0] cur_id_reg, cur_id_next;
    logic [TIME_BITS-1:0] cur_left_reg, cur_left_next;
    entry_t parked_reg, parked_next;   // job waiting to re-enter the queue
    logic shorter_reg, shorter_next;
    logic over_reg, over_next;
    logic disp_reg, disp_next;
    logic rein_sorted_reg, rein_sorted_next;

    qop_t op;
    entry_t head;
    logic [CNT_BITS-1:0] cnt;
    logic [1:0] eff_mode;
    logic full;

    cds_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .op   (op),
        .head (head),
        .count(cnt)
    );

    assign eff_mode = (mode_reg == 2'd3) ? MODE_FCFS : mode_reg;
    assign full = cnt >= CNT_BITS'(QUEUE_DEPTH);
    assign busy = st_reg != ST_IDLE;

    always_comb
    begin
        st_next = st_reg;
        run_next = run_reg;
        cur_id_next = cur_id_reg;
        cur_left_next = cur_left_reg;
        parked_next = parked_reg;
        shorter_next = shorter_reg;
        over_next = over_reg;
        disp_next = disp_reg;
        rein_sorted_next = rein_sorted_reg;
        op = '0;
        case (st_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // charge elapsed time, saturating at zero
                    if (run_reg)
                        cur_left_next = (cur_left_reg > elapsed) ?
                                        cur_left_reg - elapsed : '0;
                    shorter_next = 1'b0;
                    over_next = 1'b0;
                    disp_next = 1'b0;
                    st_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                st_next = ST_DONE;
                case (cmd_reg)
                    CMD_ARRIVE:
                    begin
                        if (!run_reg)
                        begin
                            run_next = 1'b1;
                            cur_id_next = id_reg;
                            cur_left_next = burst_reg;
                            disp_next = 1'b1;
                        end
                        else if (full)
                            over_next = 1'b1;
                        else
                        begin
                            op.ins = 1'b1;
                            op.data.id = id_reg;
                            op.data.left = burst_reg;
                            if (eff_mode == MODE_SRTF)
                            begin
                                if (burst_reg < cur_left_reg)
                                begin
                                    op.front = 1'b1;
                                    shorter_next = 1'b1;
                                end
                            end
                            else
                                op.tail = 1'b1;
                        end
                    end
                    CMD_DEPART:
                    begin
                        if (run_reg)
                        begin
                            if (cnt != '0)
                            begin
                                op.pop = 1'b1;
                                cur_id_next = head.id;
                                cur_left_next = head.left;
                                disp_next = 1'b1;
                            end
                            else
                            begin
                                run_next = 1'b0;
                                cur_id_next = '0;
                                cur_left_next = '0;
                            end
                        end
                    end
                    CMD_PREEMPT:
                    begin
                        if (run_reg && eff_mode == MODE_SRTF)
                        begin
                            if (cnt != '0 && head.left <= cur_left_reg)
                            begin
                                op.pop = 1'b1;
                                parked_next.id = cur_id_reg;
                                parked_next.left = cur_left_reg;
                                cur_id_next = head.id;
                                cur_left_next = head.left;
                                rein_sorted_next = 1'b1;
                                st_next = ST_REIN;
                            end
                        end
                        else if (run_reg && eff_mode == MODE_RR)
                        begin
                            disp_next = 1'b1;
                            if (cnt != '0)
                            begin
                                op.pop = 1'b1;
                                parked_next.id = cur_id_reg;
                                parked_next.left = cur_left_reg;
                                cur_id_next = head.id;
                                cur_left_next = head.left;
                                rein_sorted_next = 1'b0;
                                st_next = ST_REIN;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_REIN:
            begin
                op.ins = 1'b1;
                op.tail = !rein_sorted_reg;
                op.data = parked_reg;
                st_next = ST_DONE;
            end
            ST_DONE:
                st_next = ST_IDLE;
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            mode_reg <= MODE_FCFS;
            slice_reg <= TIME_BITS'(100);
            run_reg <= 1'b0;
            cur_id_reg <= '0;
            cur_left_reg <= '0;
            shorter_reg <= 1'b0;
            over_reg <= 1'b0;
            disp_reg <= 1'b0;
            rein_sorted_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            run_reg <= run_next;
            cur_id_reg <= cur_id_next;
            cur_left_reg <= cur_left_next;
            shorter_reg <= shorter_next;
            over_reg <= over_next;
            disp_reg <= disp_next;
            rein_sorted_reg <= rein_sorted_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_MODE)
                    mode_reg <= cfg_data[1:0];
                else
                    mode_reg <= mode_reg;
                if (cfg_index == CFG_SLICE)
                    slice_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        parked_reg <= parked_next;
        if (start && !busy)
        begin
            cmd_reg <= cmd;
            id_reg <= job_id;
            burst_reg <= burst;
        end
    end

    // result, shown in the done state
    always_comb
    begin
        done = st_reg == ST_DONE;
        run_valid = run_reg;
        run_id = run_reg ? cur_id_reg : '0;
        run_left = run_reg ? cur_left_reg : '0;
        req_valid = 1'b0;
        req_kind = KIND_DEPART;
        req_delay = '0;
        if (run_reg)
        begin
            if (eff_mode == MODE_SRTF)
            begin
                req_valid = 1'b1;
                if (shorter_reg)
                    req_kind = KIND_PREEMPT;
                else
                    req_delay = cur_left_reg;
            end
            else if (disp_reg)
            begin
                req_valid = 1'b1;
                if (eff_mode == MODE_RR && cur_left_reg > slice_reg)
                begin
                    req_kind = KIND_PREEMPT;
                    req_delay = slice_reg;
                end
                else
                    req_delay = cur_left_reg;
            end
        end
        queue_count = 5'(cnt);
        overflow = over_reg;
    end

    // overflow only ever follows a full queue
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |-> cnt == CNT_BITS'(QUEUE_DEPTH))
        else $error("overflow with room in queue");
    // count never exceeds depth
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    // a re-insert always comes right after execute
    a_rein: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_REIN |-> $past(st_reg) == ST_EXEC)
        else $error("re-insert out of sequence");
    // idle processor leaves queue empty after a done
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done && !run_valid |-> cnt == '0)
        else $error("jobs waiting with idle processor");
endmodule

// ----- tb/sv/cpu_dispatch_scheduler_checker.sv -----
// cpu_dispatch_scheduler_checker: predicts each scheduler item's report and
// compares it with the done strobe; depends on cds_pkg
module cpu_dispatch_scheduler_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic [1:0] cmd,
    input  logic [cds_pkg::TIME_BITS-1:0] elapsed,
    input  logic [15:0] job_id,
    input  logic [cds_pkg::TIME_BITS-1:0] burst,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [cds_pkg::TIME_BITS-1:0] cfg_data,
    input  logic done,
    input  logic run_valid,
    input  logic [15:0] run_id,
    input  logic [cds_pkg::TIME_BITS-1:0] run_left,
    input  logic req_valid,
    input  logic req_kind,
    input  logic [cds_pkg::TIME_BITS-1:0] req_delay,
    input  logic [4:0] queue_count,
    input  logic overflow,
    output int fail_count,
    output int pending
);
    import cds_pkg::*;

    localparam int REP_SLOTS = 4;

    typedef struct packed {
        logic rv;
        logic [15:0] rid;
        logic [15:0] rleft;
        logic qv;
        logic qk;
        logic [15:0] qd;
        logic [4:0] qc;
        logic ov;
    } report_t;

    // small ring of predicted reports waiting for their done strobe
    report_t rep_buf[REP_SLOTS];
    int rep_rd, rep_wr, rep_n;
    logic [1:0] sched_mode;
    logic [15:0] slice;
    logic [15:0] q_id[QUEUE_DEPTH+1];
    logic [15:0] q_left[QUEUE_DEPTH+1];
    int q_n;
    logic running;
    logic [15:0] now_id, now_left;

    assign pending = rep_n;

    function automatic void q_put(int pos, logic [15:0] id, logic [15:0] left);
        for (int i = q_n; i > pos; i--) begin
            q_id[i] = q_id[i-1];
            q_left[i] = q_left[i-1];
        end
        q_id[pos] = id;
        q_left[pos] = left;
        q_n++;
    endfunction

    function automatic void q_put_sorted(logic [15:0] id, logic [15:0] left);
        int pos;
        pos = 0;
        while (pos < q_n && q_left[pos] <= left) pos++;
        q_put(pos, id, left);
    endfunction

    function automatic void q_take(output logic [15:0] id, output logic [15:0] left);
        id = q_id[0];
        left = q_left[0];
        for (int i = 1; i < q_n; i++) begin
            q_id[i-1] = q_id[i];
            q_left[i-1] = q_left[i];
        end
        q_n--;
    endfunction

    // advance the scheduler state by one item and build its report
    function automatic report_t schedule_item(logic [1:0] c, logic [15:0] el,
                                              logic [15:0] id, logic [15:0] b);
        report_t r;
        logic [1:0] m;
        logic disp, shorter, over;
        logic [15:0] nid, nleft;
        m = (sched_mode == 2'd3) ? MODE_FCFS : sched_mode;
        disp = 0; shorter = 0; over = 0;
        r = '0;
        if (running) now_left = (now_left > el) ? now_left - el : 16'd0;
        if (c == CMD_ARRIVE) begin
            if (!running) begin
                running = 1; now_id = id; now_left = b; disp = 1;
            end else if (q_n >= QUEUE_DEPTH) over = 1;
            else if (m == MODE_SRTF) begin
                if (b < now_left) begin
                    q_put(0, id, b); shorter = 1;
                end else q_put_sorted(id, b);
            end else q_put(q_n, id, b);
        end else if (c == CMD_DEPART && running) begin
            if (q_n > 0) begin
                q_take(now_id, now_left); disp = 1;
            end else begin
                running = 0; now_id = 0; now_left = 0;
            end
        end else if (c == CMD_PREEMPT && running) begin
            if (m == MODE_SRTF) begin
                if (q_n > 0 && q_left[0] <= now_left) begin
                    q_take(nid, nleft);
                    q_put_sorted(now_id, now_left);
                    now_id = nid; now_left = nleft;
                end
            end else if (m == MODE_RR) begin
                if (q_n > 0) begin
                    q_take(nid, nleft);
                    q_put(q_n, now_id, now_left);
                    now_id = nid; now_left = nleft;
                end
                disp = 1;
            end
        end
        if (running) begin
            if (m == MODE_SRTF) begin
                r.qv = 1;
                if (shorter) begin
                    r.qk = KIND_PREEMPT; r.qd = 0;
                end else begin
                    r.qk = KIND_DEPART; r.qd = now_left;
                end
            end else if (disp) begin
                r.qv = 1;
                if (m == MODE_RR && now_left > slice) begin
                    r.qk = KIND_PREEMPT; r.qd = slice;
                end else begin
                    r.qk = KIND_DEPART; r.qd = now_left;
                end
            end
        end
        r.rv = running;
        r.rid = running ? now_id : 16'd0;
        r.rleft = running ? now_left : 16'd0;
        r.qc = q_n[4:0];
        r.ov = over;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        report_t e, a;
        if (!rst_n) begin
            sched_mode = MODE_FCFS;
            slice = 16'd100;
            q_n = 0;
            running = 0;
            now_id = 0;
            now_left = 0;
            fail_count = 0;
            rep_rd = 0;
            rep_wr = 0;
            rep_n = 0;
        end else begin
            if (done) begin
                a = '{run_valid, run_id, run_left, req_valid, req_kind, req_delay,
                      queue_count, overflow};
                if (rep_n == 0) begin
                    $display("%0t: unexpected item %h", $time, a);
                    fail_count++;
                end else begin
                    e = rep_buf[rep_rd];
                    rep_rd = (rep_rd + 1) % REP_SLOTS;
                    rep_n--;
                    if (a !== e) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, a);
                        fail_count++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_MODE) sched_mode = cfg_data[1:0];
                else slice = cfg_data;
            end
            if (start && !busy) begin
                rep_buf[rep_wr] = schedule_item(cmd, elapsed, job_id, burst);
                rep_wr = (rep_wr + 1) % REP_SLOTS;
                rep_n++;
            end
        end
    end
endmodule

// ----- tb/sv/cpu_dispatch_scheduler_unit_test.sv -----
// cpu_dispatch_scheduler_unit_test: stimulus and verdict for the scheduler
// depends on cds_pkg, cpu_dispatch_scheduler_unit and the checker
module cpu_dispatch_scheduler_unit_test;
    import cds_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic [1:0] cmd = 0;
    logic [15:0] elapsed = 0, job_id = 0, burst = 1;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [15:0] cfg_data = 0;
    logic busy, done, run_valid, req_valid, req_kind, overflow;
    logic [15:0] run_id, run_left, req_delay;
    logic [4:0] queue_count;
    int fail_count, pending;
    int idle_cycles;
    int gap_pct;

    always #5 clk = ~clk;

    cpu_dispatch_scheduler_unit u_top (.*);
    cpu_dispatch_scheduler_checker u_check (.*);

    // watchdog: cycles with no item accepted on either side
    always @(posedge clk) begin
        if ((start && !busy) || done || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // present one item and hold it until the block takes it
    task automatic send_item(logic [1:0] c, logic [15:0] el, logic [15:0] id,
                             logic [15:0] b);
        @(posedge clk);
        while ($urandom_range(99) < gap_pct) @(posedge clk);
        start <= 1;
        cmd <= c;
        elapsed <= el;
        job_id <= id;
        burst <= b;
        // wait for the edge at which busy was low, the accepting edge
        @(posedge clk iff !busy);
        start <= 0;
    endtask

    // drain all reports plus the block's latency before touching registers
    task automatic settle();
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // mostly small time values so jobs actually finish and queues fill
    function automatic logic [15:0] rand_time();
        case ($urandom_range(9))
            0: return 16'hffff;
            1: return 16'(1 + $urandom_range(65534));
            2: return 0;
            default: return 16'($urandom_range(1, 60));
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [1:0] c;
        int arr_bias;
        arr_bias = $urandom_range(30, 70);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < arr_bias) c = CMD_ARRIVE;
            else if ($urandom_range(99) < 50) c = CMD_DEPART;
            else if ($urandom_range(99) < 94) c = CMD_PREEMPT;
            else c = 2'd3;
            send_item(c, rand_time(), 16'($urandom), rand_time() | 16'd1);
            if (i == n / 2) settle();
        end
    endtask

    initial begin
        gap_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, full queue and overflow, each command, idle ops
        send_item(CMD_DEPART, 16'd5, 16'd1, 16'd1);
        send_item(CMD_PREEMPT, 16'd5, 16'd1, 16'd1);
        send_item(CMD_ARRIVE, 16'hffff, 16'hffff, 16'hffff);
        for (int i = 0; i < 17; i++)
            send_item(CMD_ARRIVE, 16'(i), 16'(i), 16'(i + 1));
        send_item(2'd3, 16'd7, 16'd0, 16'd1);
        send_item(CMD_PREEMPT, 16'hffff, 16'd0, 16'd1);
        send_item(CMD_DEPART, 16'd0, 16'd0, 16'd1);
        settle();

        // several register settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_MODE, 16'(ph % 4));
            case (ph)
                0: write_reg(CFG_SLICE, 16'd1);
                1: write_reg(CFG_SLICE, 16'hffff);
                2: write_reg(CFG_SLICE, 16'd0);
                default: write_reg(CFG_SLICE, 16'($urandom_range(1, 40)));
            endcase
            gap_pct = (ph == 5) ? 0 : 37;
            random_phase(215);
            settle();
        end
        write_reg(CFG_MODE, 16'(MODE_SRTF));
        write_reg(CFG_MODE, 16'(MODE_RR));
        random_phase(30);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/cds_pkg.sv
rtl/cds_cell.sv
rtl/cds_queue.sv
rtl/cpu_dispatch_scheduler_unit.sv
tb/sv/cpu_dispatch_scheduler_checker.sv
tb/sv/cpu_dispatch_scheduler_unit_test.sv
